// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms for the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define KBH_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define KBH_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/kbh_pkg.sv
// ----------------------------------------------------------------------------
// kbh_pkg
// types and constants shared by the key bucket hash modules
// ----------------------------------------------------------------------------
package kbh_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned OPND_W     = 13;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned TSIZE_W    = 17;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [TSIZE_W-1:0] TSIZE_RESET = 17'd1024;
  localparam logic [TSIZE_W-1:0] TSIZE_MAX   = 17'd65536;
  localparam logic [TSIZE_W-1:0] TSIZE_MIN   = 17'd1;

  // what the back end does with one queued byte
  typedef enum logic [1:0] {
    OP_ZERO,
    OP_FIRST,
    OP_SECOND,
    OP_LATER
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [OPND_W-1:0] operand;
    logic [LEN_W-1:0]  len;
    logic              last;
  } entry_t;

endpackage

// File: rtl/kbh_fifo.sv
// ----------------------------------------------------------------------------
// kbh_fifo
// short register queue between the front and the back end
// ----------------------------------------------------------------------------
module kbh_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  kbh_pkg::entry_t  push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output kbh_pkg::entry_t  head_o
);

  localparam int unsigned Depth = kbh_pkg::FIFO_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  kbh_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/kbh_front.sv
// ----------------------------------------------------------------------------
// kbh_front
// takes key bytes, tracks the byte position and classifies each byte
// ----------------------------------------------------------------------------
module kbh_front #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kbh_pkg::BYTE_W-1:0]  key_byte_i,
  input  logic [kbh_pkg::LEN_W-1:0]   key_length_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output kbh_pkg::entry_t             push_data_o
);

  logic [kbh_pkg::LEN_W-1:0]  pos_q, pos_d;
  logic [kbh_pkg::LEN_W-1:0]  len;
  logic [kbh_pkg::LEN_W:0]    pos_inc;
  logic                       last;
  kbh_pkg::op_e               op;
  logic [kbh_pkg::OPND_W-1:0] operand;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    // overlong keys count as the longest allowed
    if (32'(key_length_i) > MAX_KEY_BYTES) begin
      len = kbh_pkg::LEN_W'(MAX_KEY_BYTES);
    end else begin
      len = key_length_i;
    end

    pos_inc = {1'b0, pos_q} + 1'b1;
    last    = (len == '0) || (pos_inc >= {1'b0, len});

    if (len == '0) begin
      op = kbh_pkg::OP_ZERO;
    end else if (pos_q == kbh_pkg::LEN_W'(0)) begin
      op = kbh_pkg::OP_FIRST;
    end else if (pos_q == kbh_pkg::LEN_W'(1)) begin
      op = kbh_pkg::OP_SECOND;
    end else begin
      op = kbh_pkg::OP_LATER;
    end

    unique case (op)
      kbh_pkg::OP_ZERO:   operand = '0;
      kbh_pkg::OP_FIRST:  operand = kbh_pkg::OPND_W'(key_byte_i);
      kbh_pkg::OP_SECOND: operand = kbh_pkg::OPND_W'(key_byte_i) * kbh_pkg::OPND_W'(len);
      kbh_pkg::OP_LATER:  operand = kbh_pkg::OPND_W'(key_byte_i) * kbh_pkg::OPND_W'(pos_q)
                                    + kbh_pkg::OPND_W'(len) + kbh_pkg::OPND_W'(pos_q);
      default:            operand = '0;
    endcase

    pos_d = last ? '0 : pos_inc[kbh_pkg::LEN_W-1:0];

    push_data_o.op      = op;
    push_data_o.operand = operand;
    push_data_o.len     = len;
    push_data_o.last    = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (push_o) begin
      pos_q <= pos_d;
    end
  end

endmodule

// File: rtl/kbh_back.sv
// ----------------------------------------------------------------------------
// kbh_back
// accumulator update, final scale and bit-serial modulo by the table size
// ----------------------------------------------------------------------------
module kbh_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [kbh_pkg::TSIZE_W-1:0]  cfg_wdata_i,
  input  logic                         q_empty_i,
  input  kbh_pkg::entry_t              head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [kbh_pkg::IDX_W-1:0]    bucket_index_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_DONE
  } state_e;

  localparam int unsigned CntW = $clog2(kbh_pkg::ACC_W);

  state_e                      state_q;
  logic [kbh_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic [kbh_pkg::ACC_W-1:0]   h_q;
  logic [kbh_pkg::LEN_W-1:0]   len_q;
  logic [kbh_pkg::IDX_W-1:0]   rem_q, rem_d;
  logic [CntW-1:0]             cnt_q;
  logic [kbh_pkg::TSIZE_W-1:0] tsize_q;
  logic [kbh_pkg::TSIZE_W-1:0] modulus;
  logic [kbh_pkg::TSIZE_W-1:0] trial;
  logic                        out_valid_q;
  logic [kbh_pkg::IDX_W-1:0]   out_q;
  logic                        out_free;

  assign pop_o          = (state_q == ST_IDLE) && !q_empty_i;
  assign out_valid_o    = out_valid_q;
  assign bucket_index_o = out_q;
  assign out_free       = !out_valid_q || out_ready_i;

  always_comb begin
    if (tsize_q == '0) begin
      modulus = kbh_pkg::TSIZE_MIN;
    end else if (tsize_q > kbh_pkg::TSIZE_MAX) begin
      modulus = kbh_pkg::TSIZE_MAX;
    end else begin
      modulus = tsize_q;
    end

    unique case (head_i.op)
      kbh_pkg::OP_ZERO:   acc_d = '0;
      kbh_pkg::OP_FIRST:  acc_d = kbh_pkg::ACC_W'(head_i.operand);
      kbh_pkg::OP_SECOND: acc_d = acc_q + kbh_pkg::ACC_W'(head_i.operand);
      kbh_pkg::OP_LATER:  acc_d = acc_q * kbh_pkg::ACC_W'(head_i.operand);
      default:            acc_d = acc_q;
    endcase

    // restoring step: remainder stays below the modulus
    trial = {rem_q, h_q[kbh_pkg::ACC_W-1]};
    if (trial >= modulus) begin
      rem_d = kbh_pkg::IDX_W'(trial - modulus);
    end else begin
      rem_d = trial[kbh_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      h_q         <= '0;
      len_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      tsize_q     <= kbh_pkg::TSIZE_RESET;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        tsize_q <= cfg_wdata_i;
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
        out_q       <= rem_q;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            acc_q <= acc_d;
            len_q <= head_i.len;
            if (head_i.last) begin
              state_q <= ST_HASH;
            end
          end
        end
        ST_HASH: begin
          h_q     <= acc_q * kbh_pkg::ACC_W'(len_q);
          acc_q   <= '0;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_MOD;
        end
        ST_MOD: begin
          h_q   <= {h_q[kbh_pkg::ACC_W-2:0], 1'b0};
          rem_q <= rem_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(kbh_pkg::ACC_W - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/key_bucket_hash_top.sv
// ----------------------------------------------------------------------------
// key_bucket_hash_top
// byte-serial bucket hash of a key, reduced modulo the table size
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  input    | in_valid_i / in_ready_o | key_byte_i, key_length_i
//  output   | out_valid_o/out_ready_i | bucket_index_o
//  config   | cfg_we_i                | cfg_wdata_i (table size)
//
// the front takes one byte a cycle while the 4-entry queue has room
// the back end folds each queued byte into the accumulator while idle
// a completed key then passes a scale state, 32 modulo steps and a done state
// reset clears position, accumulator, queue and result; table size goes to 1024
// a waiting result holds the back end, bytes keep queuing until the queue fills
module key_bucket_hash_top #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [kbh_pkg::BYTE_W-1:0]   key_byte_i,
  input  logic [kbh_pkg::LEN_W-1:0]    key_length_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [kbh_pkg::IDX_W-1:0]    bucket_index_o,
  input  logic                         cfg_we_i,
  input  logic [kbh_pkg::TSIZE_W-1:0]  cfg_wdata_i
);

  logic            q_full, q_empty, push, pop;
  kbh_pkg::entry_t push_data, head;

  kbh_front #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .key_byte_i   (key_byte_i),
    .key_length_i (key_length_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  kbh_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  kbh_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_empty_i      (q_empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .bucket_index_o (bucket_index_o)
  );

endmodule

// File: rtl/kbh_checker.sv
// ----------------------------------------------------------------------------
// kbh_checker
// port-level checks on the key bucket hash, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kbh_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [kbh_pkg::IDX_W-1:0]    bucket_index_o,
  input logic                         cfg_we_i,
  input logic [kbh_pkg::TSIZE_W-1:0]  cfg_wdata_i
);

  logic [kbh_pkg::TSIZE_W-1:0] tsize_q;
  logic [kbh_pkg::TSIZE_W-1:0] modulus;

  // mirror of the configured table size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsize_q <= kbh_pkg::TSIZE_RESET;
    end else if (cfg_we_i) begin
      tsize_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (tsize_q == '0) begin
      modulus = kbh_pkg::TSIZE_MIN;
    end else if (tsize_q > kbh_pkg::TSIZE_MAX) begin
      modulus = kbh_pkg::TSIZE_MAX;
    end else begin
      modulus = tsize_q;
    end
  end

  `KBH_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(bucket_index_o), "result dropped or changed while stalled")
  `KBH_ASSERT(a_idx_range, clk_i, rst_ni, out_valid_o |-> ({1'b0, bucket_index_o} < modulus), "bucket index not below table size")
  `KBH_ASSERT_ALWAYS(a_quiet_after_reset, clk_i, !rst_ni |=> !out_valid_o, "result shown right after reset")

endmodule

bind key_bucket_hash_top kbh_checker u_kbh_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .bucket_index_o (bucket_index_o),
  .cfg_we_i       (cfg_we_i),
  .cfg_wdata_i    (cfg_wdata_i)
);

// File: verif/tb_key_bucket_hash_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_bucket_hash_top
// keys are fed byte by byte under random sender gaps and receiver stalls;
// every bucket index is checked against a bit-exact hash predictor, across
// table sizes from zero and one up to the full 17-bit range
// ----------------------------------------------------------------------------
module tb_key_bucket_hash_top;

  localparam int unsigned KEY_BYTES_MAX = 16;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS   = 105;
  localparam int unsigned NUM_PHASES    = 8;

  typedef struct packed {
    logic [kbh_pkg::BYTE_W-1:0] kbyte;
    logic [kbh_pkg::LEN_W-1:0]  klen;
  } key_item_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [kbh_pkg::BYTE_W-1:0]   key_byte_i = '0;
  logic [kbh_pkg::LEN_W-1:0]    key_length_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [kbh_pkg::IDX_W-1:0]    bucket_index_o;
  logic                         cfg_we_i = 1'b0;
  logic [kbh_pkg::TSIZE_W-1:0]  cfg_wdata_i = '0;

  key_item_t                    key_items[$];
  logic [kbh_pkg::IDX_W-1:0]    expected_buckets[$];

  // predictor state
  logic [31:0]                  hash_acc = '0;
  logic [31:0]                  hash_pos = '0;
  logic [kbh_pkg::TSIZE_W-1:0]  bucket_count = kbh_pkg::TSIZE_RESET;

  logic                         in_taken = 1'b0;
  logic                         idle_on = 1'b1;
  int unsigned                  in_gap = 0;
  int unsigned                  out_stall = 0;
  int unsigned                  items_queued = 0;
  int unsigned                  items_accepted = 0;
  int unsigned                  results_checked = 0;
  int unsigned                  mismatches = 0;
  int unsigned                  sizes_used = 1;

  key_bucket_hash_top #(
    .MAX_KEY_BYTES(KEY_BYTES_MAX)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .key_byte_i    (key_byte_i),
    .key_length_i  (key_length_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bucket_index_o(bucket_index_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // advance the hash by one accepted byte, queue a bucket when a key completes
  function automatic void predict_bucket(input logic [kbh_pkg::BYTE_W-1:0] kb,
                                         input logic [kbh_pkg::LEN_W-1:0] kl);
    logic [31:0] s;
    logic [31:0] b;
    logic [31:0] modulus;
    logic [31:0] scaled;
    s = (kl > KEY_BYTES_MAX) ? 32'(KEY_BYTES_MAX) : 32'(kl);
    b = 32'(kb);
    if (s == 0) begin
      // empty key: byte ignored, bucket 0
      hash_acc = '0;
      hash_pos = '0;
      expected_buckets.push_back('0);
      return;
    end
    if (hash_pos == 0) begin
      hash_acc = b;
    end else if (hash_pos == 1) begin
      hash_acc = hash_acc + b * s;
    end else begin
      hash_acc = hash_acc * (b * hash_pos + s + hash_pos);
    end
    if (hash_pos + 1 >= s) begin
      if (bucket_count == 0) begin
        modulus = 32'd1;
      end else if (bucket_count > kbh_pkg::TSIZE_MAX) begin
        modulus = 32'(kbh_pkg::TSIZE_MAX);
      end else begin
        modulus = 32'(bucket_count);
      end
      scaled = hash_acc * s;
      expected_buckets.push_back(kbh_pkg::IDX_W'(scaled % modulus));
      hash_acc = '0;
      hash_pos = '0;
    end else begin
      hash_pos = hash_pos + 1;
    end
  endfunction

  task automatic note_mismatch(input string what, input logic [kbh_pkg::IDX_W-1:0] want,
                               input logic [kbh_pkg::IDX_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic push_item(input logic [kbh_pkg::BYTE_W-1:0] kb,
                           input logic [kbh_pkg::LEN_W-1:0] kl);
    key_item_t it;
    it.kbyte = kb;
    it.klen = kl;
    key_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_key(input logic [kbh_pkg::LEN_W-1:0] kl);
    int unsigned nbytes;
    nbytes = (kl == 0) ? 1 : ((kl > KEY_BYTES_MAX) ? KEY_BYTES_MAX : kl);
    for (int k = 0; k < nbytes; k++) begin
      push_item(8'($urandom), kl);
    end
  endtask

  // mostly whole keys, short ones most often; some empty, oversized and broken keys
  task automatic push_random_keys(input int unsigned n_items);
    int unsigned start;
    int unsigned sel;
    int unsigned first_len;
    start = items_queued;
    while (items_queued - start < n_items) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        push_key(5'd0);
      end else if (sel == 1) begin
        push_key(5'($urandom_range(KEY_BYTES_MAX + 1, 31)));
      end else if (sel == 2) begin
        // length changes partway through a key
        first_len = $urandom_range(3, KEY_BYTES_MAX);
        for (int k = 0; k < $urandom_range(1, first_len - 1); k++) begin
          push_item(8'($urandom), 5'(first_len));
        end
        for (int k = 0; k < $urandom_range(1, 3); k++) begin
          push_item(8'($urandom), 5'($urandom_range(1, KEY_BYTES_MAX)));
        end
      end else if (sel < 6) begin
        push_key(5'($urandom_range(1, KEY_BYTES_MAX)));
      end else begin
        push_key(5'($urandom_range(1, 6)));
      end
    end
  endtask

  // let everything queued be taken and every bucket arrive, then let the block settle
  task automatic drain_all();
    while (items_accepted != items_queued || expected_buckets.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_bucket_count(input logic [kbh_pkg::TSIZE_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    bucket_count = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sizes_used++;
  endtask

  // sender: inputs change on the falling edge
  always @(negedge clk_i) begin
    key_item_t it;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (key_items.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 15);
        in_valid_i <= 1'b0;
      end else if (key_items.size() != 0) begin
        it = key_items.pop_front();
        in_valid_i <= 1'b1;
        key_byte_i <= it.kbyte;
        key_length_i <= it.klen;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall = $urandom_range(0, 15);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // both channels sampled on the rising edge; predict before checking
  always @(posedge clk_i) begin
    logic [kbh_pkg::IDX_W-1:0] want;
    if (rst_ni) begin
      in_taken = in_valid_i && in_ready_o;
      if (in_taken) begin
        items_accepted++;
        predict_bucket(key_byte_i, key_length_i);
      end
      if (out_valid_o && out_ready_i) begin
        results_checked++;
        if (expected_buckets.size() == 0) begin
          note_mismatch("bucket index with none expected", '0, bucket_index_o);
        end else begin
          want = expected_buckets.pop_front();
          if (bucket_index_o !== want) begin
            note_mismatch("bucket_index", want, bucket_index_o);
          end
        end
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  initial begin
    logic [kbh_pkg::TSIZE_W-1:0] size_plan [NUM_PHASES];
    size_plan[0] = kbh_pkg::TSIZE_MIN;
    size_plan[1] = kbh_pkg::TSIZE_MAX;
    size_plan[2] = '0;
    size_plan[3] = '1;
    size_plan[4] = 17'd65535;
    size_plan[5] = 17'($urandom_range(2, 65536));
    size_plan[6] = 17'd3;
    size_plan[7] = 17'($urandom);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed keys at the reset table size
    push_item(8'hFF, 5'd0);
    push_item(8'hFF, 5'd1);
    push_item(8'h00, 5'd2);
    push_item(8'hFF, 5'd2);
    push_item(8'h80, 5'd5);
    push_item(8'h01, 5'd5);
    push_item(8'hFF, 5'd3);
    for (int k = 0; k < KEY_BYTES_MAX; k++) begin
      push_item(8'(k * 17), 5'd31);
    end
    drain_all();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_bucket_count(size_plan[p]);
      if (p == NUM_PHASES - 1) begin
        idle_on = 1'b0;
      end
      @(posedge clk_i);
      push_random_keys(PHASE_ITEMS);
      drain_all();
    end

    if (expected_buckets.size() != 0) begin
      mismatches += expected_buckets.size();
      $display("%0d expected bucket indexes never arrived", expected_buckets.size());
    end
    $display("%0d key bytes hashed, %0d bucket indexes checked over %0d table sizes",
             items_accepted, results_checked, sizes_used);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d bytes accepted, %0d buckets outstanding",
             items_accepted, expected_buckets.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
